### rtl/ibpfc_pkg.sv
package ibpfc_pkg;

  localparam int WIDTH_W  = 16;
  localparam int HALF_W   = 7;
  localparam int SYMBOL_W = 4;
  localparam int COUNT_W  = 8;
  localparam int NUM_DIRS = 6;
  localparam int NUM_WIN  = 8;
  localparam int CENTER_W = 10;

  localparam logic [HALF_W-1:0] HALF_WIDTH_RESET = 7'd15;

  // Symbol codes as reported on the result channel
  localparam logic [SYMBOL_W-1:0] SYM_HEADER   = 4'd0;
  localparam logic [SYMBOL_W-1:0] SYM_LONG_R   = 4'd1;
  localparam logic [SYMBOL_W-1:0] SYM_LONG_C   = 4'd2;
  localparam logic [SYMBOL_W-1:0] SYM_LONG_L   = 4'd3;
  localparam logic [SYMBOL_W-1:0] SYM_SHORT_R  = 4'd4;
  localparam logic [SYMBOL_W-1:0] SYM_SHORT_C  = 4'd5;
  localparam logic [SYMBOL_W-1:0] SYM_SHORT_L  = 4'd6;
  localparam logic [SYMBOL_W-1:0] SYM_TAIL     = 4'd7;
  localparam logic [SYMBOL_W-1:0] SYM_ERROR    = 4'd8;
  localparam logic [SYMBOL_W-1:0] SYM_NONE     = 4'd9;

  localparam logic ACT_PULSE     = 1'b0;
  localparam logic ACT_BURST_END = 1'b1;

  // Windows listed lowest priority first: the last listed match wins
  localparam logic [NUM_WIN-1:0][CENTER_W-1:0] WIN_CENTER = {
    10'd750, 10'd650, 10'd550, 10'd75, 10'd150, 10'd225, 10'd825, 10'd1000
  };
  localparam logic [NUM_WIN-1:0][SYMBOL_W-1:0] WIN_CODE = {
    SYM_SHORT_L, SYM_SHORT_C, SYM_SHORT_R, SYM_LONG_L,
    SYM_LONG_C, SYM_LONG_R, SYM_TAIL, SYM_HEADER
  };

  typedef logic [NUM_DIRS-1:0][COUNT_W-1:0] counts_t;

  // One classified request presented to the frame tracker
  typedef struct packed {
    logic                fire;
    logic                action;
    logic [SYMBOL_W-1:0] symbol;
  } step_req_t;

endpackage

### rtl/ir_beacon_pulse_frame_counter_core.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_action, in_pulse_width
// out     | output    | out_valid / out_ready | out_symbol, out_frame_committed, six counts
// cfg     | input     | cfg_we (no wait)      | cfg_wdata (window half width)
//
// Input reg feeds result reg; one request per cycle sustained unless out_ready stalls.
// Throughput is set by the single classify + counter-update pass between the input
// register and the result register.
// Synchronous active-low reset: frame phase waits for header, all counts zero,
// half width 15, both register stages empty.
// A stalled result holds both stages; in_ready drops only when both are full.
module ir_beacon_pulse_frame_counter_core
  import ibpfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [WIDTH_W-1:0]  in_pulse_width,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYMBOL_W-1:0] out_symbol,
  output logic                out_frame_committed,
  output logic [COUNT_W-1:0]  out_long_right_count,
  output logic [COUNT_W-1:0]  out_long_center_count,
  output logic [COUNT_W-1:0]  out_long_left_count,
  output logic [COUNT_W-1:0]  out_short_right_count,
  output logic [COUNT_W-1:0]  out_short_center_count,
  output logic [COUNT_W-1:0]  out_short_left_count,

  input  logic                cfg_we,
  input  logic [HALF_W-1:0]   cfg_wdata
);

  // Window half width register
  logic [HALF_W-1:0] half_width_r;

  // Input stage
  logic               in_vld_r;
  logic               in_action_r;
  logic [WIDTH_W-1:0] in_width_r;

  // Result stage
  logic                out_vld_r;
  logic [SYMBOL_W-1:0] out_symbol_r;
  logic                out_commit_r;

  logic                out_advance;
  logic                fire;
  logic [SYMBOL_W-1:0] class_symbol;
  logic [SYMBOL_W-1:0] result_symbol;
  logic                commit;
  step_req_t           step_req;
  counts_t             committed;

  // Result stage can load when empty or being drained this cycle
  assign out_advance = !out_vld_r || out_ready;
  assign fire        = in_vld_r && out_advance;
  assign in_ready    = !in_vld_r || out_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RESET;
    end else if (cfg_we) begin
      half_width_r <= cfg_wdata;
    end
  end

  // Capture the request; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_action_r <= in_action;
      in_width_r  <= in_pulse_width;
    end
  end

  ibpfc_classify u_classify (
    .pulse_width_i (in_width_r),
    .half_width_i  (half_width_r),
    .symbol_o      (class_symbol)
  );

  // Burst end reports no symbol
  assign result_symbol = (in_action_r == ACT_BURST_END) ? SYM_NONE : class_symbol;

  assign step_req = '{fire: fire, action: in_action_r, symbol: class_symbol};

  ibpfc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_i       (step_req),
    .commit_o    (commit),
    .committed_o (committed)
  );

  // Hold the result until taken; committed counts update on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_symbol_r <= result_symbol;
      out_commit_r <= commit;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_symbol             = out_symbol_r;
  assign out_frame_committed    = out_commit_r;
  assign out_long_right_count   = committed[0];
  assign out_long_center_count  = committed[1];
  assign out_long_left_count    = committed[2];
  assign out_short_right_count  = committed[3];
  assign out_short_center_count = committed[4];
  assign out_short_left_count   = committed[5];

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_advance) |=> in_vld_r)
    else $error("pending request lost during output stall");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed request produced no result");

  a_commit_flag_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_commit_r) |-> out_symbol_r == SYM_TAIL)
    else $error("commit flag on non-tail result");

endmodule

### rtl/ibpfc_classify.sv
module ibpfc_classify
  import ibpfc_pkg::*;
(
  input  logic [WIDTH_W-1:0]  pulse_width_i,
  input  logic [HALF_W-1:0]   half_width_i,
  output logic [SYMBOL_W-1:0] symbol_o
);

  logic [NUM_WIN-1:0] hit;
  logic [WIDTH_W:0]   width_plus_h;

  assign width_plus_h = {1'b0, pulse_width_i} + {{(WIDTH_W+1-HALF_W){1'b0}}, half_width_i};

  // Strict window: center - h < width < center + h
  always_comb begin
    for (int k = 0; k < NUM_WIN; k++) begin
      hit[k] = (width_plus_h > {{(WIDTH_W+1-CENTER_W){1'b0}}, WIN_CENTER[k]}) &&
               ({1'b0, pulse_width_i} <
                ({{(WIDTH_W+1-CENTER_W){1'b0}}, WIN_CENTER[k]} +
                 {{(WIDTH_W+1-HALF_W){1'b0}}, half_width_i}));
    end
  end

  always_comb begin
    symbol_o = SYM_ERROR;
    for (int k = NUM_WIN - 1; k >= 0; k--) begin
      if (hit[k]) symbol_o = WIN_CODE[k];
    end
  end

endmodule

### rtl/ibpfc_frame.sv
module ibpfc_frame
  import ibpfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  step_req_t req_i,
  output logic      commit_o,
  output counts_t   committed_o
);

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_CLOSED  = 2'd2
  } phase_t;

  phase_t  phase_r, phase_nxt;
  counts_t running_r, running_nxt;
  counts_t committed_r, committed_nxt;

  always_comb begin
    phase_nxt     = phase_r;
    running_nxt   = running_r;
    committed_nxt = committed_r;
    commit_o      = 1'b0;
    if (req_i.fire) begin
      if (req_i.action == ACT_BURST_END) begin
        running_nxt = '0;
        phase_nxt   = PH_WAIT;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (req_i.symbol == SYM_HEADER) phase_nxt = PH_COLLECT;
          end
          PH_COLLECT: begin
            case (req_i.symbol) inside
              [SYM_LONG_R:SYM_SHORT_L]: begin
                for (int d = 0; d < NUM_DIRS; d++) begin
                  if (req_i.symbol == SYM_LONG_R + SYMBOL_W'(d) &&
                      running_r[d] != '1) begin
                    running_nxt[d] = running_r[d] + COUNT_W'(1);
                  end
                end
              end
              SYM_TAIL: begin
                committed_nxt = running_r;
                commit_o      = 1'b1;
                phase_nxt     = PH_CLOSED;
              end
              SYM_HEADER: begin
                running_nxt = '0;
                phase_nxt   = PH_CLOSED;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      running_r   <= '0;
      committed_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      running_r   <= running_nxt;
      committed_r <= committed_nxt;
    end
  end

  assign committed_o = committed_r;

  a_commit_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    commit_o |-> (req_i.symbol == SYM_TAIL && phase_r == PH_COLLECT))
    else $error("commit without tail while collecting");

  a_commit_copies: assert property (@(posedge clk) disable iff (!rst_n)
    commit_o |=> committed_r == $past(running_r))
    else $error("committed counts differ from running counts");

  a_burst_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (req_i.fire && req_i.action == ACT_BURST_END) |=> (running_r == '0 && phase_r == PH_WAIT))
    else $error("burst end did not rearm");

  a_wait_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WAIT) |-> (running_r == '0))
    else $error("running counts nonzero while waiting for header");

endmodule
